### src/neighbor_partition_move_gain_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the move gain block
// Shorthand for clocked assertions that are off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_PARTITION_MOVE_GAIN_TOP_MACROS_SVH
`define NEIGHBOR_PARTITION_MOVE_GAIN_TOP_MACROS_SVH

// same-cycle implication
`define NPMG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NPMG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/npmg_pkg.sv
// ----------------------------------------------------------------------------
// npmg_pkg
// Widths, stream layout and shared types of the move gain block.
// ----------------------------------------------------------------------------
package npmg_pkg;

    localparam int MAX_PARTS = 64;
    localparam int PART_W    = $clog2(MAX_PARTS);
    localparam int COUNT_W   = 16;
    localparam int NODE_W    = 31;
    localparam int ACTIVE_W  = $clog2(MAX_PARTS + 1);
    localparam int GAIN_W    = 16;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(MAX_PARTS);
    localparam logic [ACTIVE_W-1:0] ACTIVE_MIN   = ACTIVE_W'(1);

    // input tdata layout
    localparam int IN_NODE_LO = 0;
    localparam int IN_OWN_LO  = IN_NODE_LO + NODE_W;
    localparam int IN_NB_LO   = IN_OWN_LO + PART_W;
    localparam int IN_BITS    = IN_NB_LO + PART_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_NODE_LO = 0;
    localparam int OUT_FROM_LO = OUT_NODE_LO + NODE_W;
    localparam int OUT_TO_LO   = OUT_FROM_LO + PART_W;
    localparam int OUT_GAIN_LO = OUT_TO_LO + PART_W;
    localparam int OUT_MOVE_B  = OUT_GAIN_LO + GAIN_W;
    localparam int OUT_BAD_B   = OUT_MOVE_B + 1;
    localparam int OUT_BITS    = OUT_BAD_B + 1;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [PART_W-1:0]  part_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam count_t COUNT_MAX = '1;

    // count update from the working stage to the count store
    typedef struct packed {
        logic   en;    // write data to addr
        logic   clr;   // end of run: forget every count
        part_t  addr;
        count_t data;
    } wr_t;

endpackage

### src/npmg_count_store.sv
// ----------------------------------------------------------------------------
// npmg_count_store
// Per-partition neighbour counts: memory with registered reads, valid bits
// cleared together at the end of a run, and forwarding of the write made
// at the read edge.
// ----------------------------------------------------------------------------
module npmg_count_store
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  npmg_pkg::part_t rd_nb_addr,
    input  npmg_pkg::part_t rd_own_addr,
    input  npmg_pkg::wr_t   wr,
    output npmg_pkg::count_t nb_count,
    output npmg_pkg::count_t own_count
);

    npmg_pkg::count_t mem [npmg_pkg::MAX_PARTS];

    npmg_pkg::count_t nb_q_reg;
    npmg_pkg::count_t own_q_reg;
    npmg_pkg::part_t  nb_addr_reg;
    npmg_pkg::part_t  own_addr_reg;
    logic             fwd_valid_reg;
    npmg_pkg::part_t  fwd_addr_reg;
    npmg_pkg::count_t fwd_data_reg;
    logic [npmg_pkg::MAX_PARTS-1:0] vld_reg;

    // memory write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered reads, with a note of the write landing at the same edge
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            nb_q_reg     <= mem[rd_nb_addr];
            own_q_reg    <= mem[rd_own_addr];
            nb_addr_reg  <= rd_nb_addr;
            own_addr_reg <= rd_own_addr;
            fwd_addr_reg <= wr.addr;
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_valid_reg <= wr.en && !wr.clr;
        end
    end

    // valid bits: an entry not written in this run reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.clr)
        begin
            vld_reg <= '0;
        end
        else if (wr.en)
        begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    // resolve the counts seen by the item in the working stage
    always_comb
    begin
        if (!vld_reg[nb_addr_reg])
        begin
            nb_count = '0;
        end
        else if (fwd_valid_reg && fwd_addr_reg == nb_addr_reg)
        begin
            nb_count = fwd_data_reg;
        end
        else
        begin
            nb_count = nb_q_reg;
        end

        if (!vld_reg[own_addr_reg])
        begin
            own_count = '0;
        end
        else if (fwd_valid_reg && fwd_addr_reg == own_addr_reg)
        begin
            own_count = fwd_data_reg;
        end
        else
        begin
            own_count = own_q_reg;
        end
    end

endmodule

### src/neighbor_partition_move_gain_top.sv
// ----------------------------------------------------------------------------
// neighbor_partition_move_gain_top
// Neighbour partition histogram and move gain for label propagation.
// ----------------------------------------------------------------------------
// One neighbour item is taken every cycle unless the working stage holds,
// including the cycle after a run ends. Each item passes through one working
// stage, and a node's result is registered as its last item leaves that stage.
// The count memory is read as the item is taken and written as the item
// leaves the working stage; the write of the item ahead is forwarded. The
// working stage only holds while a finished result waits on the output and a
// further last item arrives. Counts are forgotten at the end of each run
// through per-entry valid bits, so there is no clearing pass. active_parts is
// to be written through cfg_wr_en/cfg_wr_data while idle; the block itself
// does not enforce this. Values outside 1..64 act as the nearest limit.
// ----------------------------------------------------------------------------
`include "neighbor_partition_move_gain_top_macros.svh"

module neighbor_partition_move_gain_top
(
    input  logic clk,
    input  logic rst_n,

    input  logic                              cfg_wr_en,
    input  logic [npmg_pkg::ACTIVE_W-1:0]     cfg_wr_data,   // active_parts

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // node_id, own_part, neighbor_part, zero fill
    input  logic [npmg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tuser,  // has_neighbor
    input  logic                              s_axis_tlast,  // last

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // node_out, from_part, to_part, gain, move, bad_part, zero fill
    output logic [npmg_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    logic [npmg_pkg::ACTIVE_W-1:0] lim_reg;

    logic                          s1_valid_reg;
    logic [npmg_pkg::NODE_W-1:0]   s1_node_reg;
    npmg_pkg::part_t               s1_own_reg;
    npmg_pkg::part_t               s1_nb_reg;
    logic                          s1_has_reg;
    logic                          s1_last_reg;

    npmg_pkg::count_t              best_count_reg;
    npmg_pkg::count_t              best_count_next;
    npmg_pkg::part_t               best_index_reg;
    npmg_pkg::part_t               best_index_next;
    logic                          bad_reg;
    logic                          bad_next;

    logic                          out_valid_reg;
    logic [npmg_pkg::NODE_W-1:0]   out_node_reg;
    npmg_pkg::part_t               out_from_reg;
    npmg_pkg::part_t               out_to_reg;
    logic [npmg_pkg::GAIN_W-1:0]   out_gain_reg;
    logic                          out_move_reg;
    logic                          out_bad_reg;

    logic                          s_fire;
    logic                          s1_adv;
    logic                          nb_in_range;
    logic                          own_in_range;
    logic                          counted;
    npmg_pkg::count_t              nb_cur;
    npmg_pkg::count_t              own_cur;
    npmg_pkg::count_t              nb_new;
    npmg_pkg::count_t              own_final;
    npmg_pkg::count_t              diff;
    npmg_pkg::wr_t                 wr;

    // handshake
    assign s1_adv        = s1_valid_reg && (!s1_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // active partition count, clamped on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= npmg_pkg::ACTIVE_RESET;
        end
        else if (cfg_wr_en)
        begin
            priority if (cfg_wr_data < npmg_pkg::ACTIVE_MIN)
            begin
                lim_reg <= npmg_pkg::ACTIVE_MIN;
            end
            else if (cfg_wr_data > npmg_pkg::ACTIVE_RESET)
            begin
                lim_reg <= npmg_pkg::ACTIVE_RESET;
            end
            else
            begin
                lim_reg <= cfg_wr_data;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_node_reg <= s_axis_tdata[npmg_pkg::IN_NODE_LO +: npmg_pkg::NODE_W];
            s1_own_reg  <= s_axis_tdata[npmg_pkg::IN_OWN_LO +: npmg_pkg::PART_W];
            s1_nb_reg   <= s_axis_tdata[npmg_pkg::IN_NB_LO +: npmg_pkg::PART_W];
            s1_has_reg  <= s_axis_tuser;
            s1_last_reg <= s_axis_tlast;
        end
    end

    // count store
    npmg_count_store u_store
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (s_fire),
        .rd_nb_addr  (s_axis_tdata[npmg_pkg::IN_NB_LO +: npmg_pkg::PART_W]),
        .rd_own_addr (s_axis_tdata[npmg_pkg::IN_OWN_LO +: npmg_pkg::PART_W]),
        .wr          (wr),
        .nb_count    (nb_cur),
        .own_count   (own_cur)
    );

    // count the neighbour and update the running best
    always_comb
    begin
        nb_in_range  = {1'b0, s1_nb_reg} < lim_reg;
        own_in_range = {1'b0, s1_own_reg} < lim_reg;
        counted      = s1_has_reg && nb_in_range && (nb_cur != npmg_pkg::COUNT_MAX);
        nb_new       = nb_cur + npmg_pkg::count_t'(1);
        bad_next     = bad_reg || (s1_has_reg && !nb_in_range);

        best_count_next = best_count_reg;
        best_index_next = best_index_reg;
        if (counted && (nb_new > best_count_reg
                        || (nb_new == best_count_reg && s1_nb_reg < best_index_reg)))
        begin
            best_count_next = nb_new;
            best_index_next = s1_nb_reg;
        end

        // own count after this item's increment
        priority if (!own_in_range)
        begin
            own_final = '0;
        end
        else if (counted && s1_nb_reg == s1_own_reg)
        begin
            own_final = nb_new;
        end
        else
        begin
            own_final = own_cur;
        end
        diff = best_count_next - own_final;

        wr.en   = s1_adv && counted && !s1_last_reg;
        wr.clr  = s1_adv && s1_last_reg;
        wr.addr = s1_nb_reg;
        wr.data = nb_new;
    end

    // running state of the current run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_count_reg <= '0;
            best_index_reg <= '0;
            bad_reg        <= 1'b0;
        end
        else if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                best_count_reg <= '0;
                best_index_reg <= '0;
                bad_reg        <= 1'b0;
            end
            else
            begin
                best_count_reg <= best_count_next;
                best_index_reg <= best_index_next;
                bad_reg        <= bad_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // gain and count share one width, so the difference never needs clipping
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
        begin
            out_node_reg <= s1_node_reg;
            out_from_reg <= s1_own_reg;
            out_to_reg   <= best_index_next;
            out_gain_reg <= npmg_pkg::GAIN_W'(diff);
            out_move_reg <= diff != '0;
            out_bad_reg  <= bad_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[npmg_pkg::OUT_NODE_LO +: npmg_pkg::NODE_W] = out_node_reg;
        m_axis_tdata[npmg_pkg::OUT_FROM_LO +: npmg_pkg::PART_W] = out_from_reg;
        m_axis_tdata[npmg_pkg::OUT_TO_LO +: npmg_pkg::PART_W]   = out_to_reg;
        m_axis_tdata[npmg_pkg::OUT_GAIN_LO +: npmg_pkg::GAIN_W] = out_gain_reg;
        m_axis_tdata[npmg_pkg::OUT_MOVE_B]                      = out_move_reg;
        m_axis_tdata[npmg_pkg::OUT_BAD_B]                       = out_bad_reg;
    end

    // checks
    `NPMG_ASSERT_NXT(a_last_gives_result, s1_adv && s1_last_reg, out_valid_reg,
        "last item did not produce a result")
    `NPMG_ASSERT_NOW(a_move_matches_gain, out_valid_reg, out_move_reg == (out_gain_reg != '0),
        "move flag disagrees with gain")
    `NPMG_ASSERT_NOW(a_move_changes_part, out_valid_reg && out_move_reg,
        out_to_reg != out_from_reg, "move candidate targets its own partition")

endmodule

### test/tb_neighbor_partition_move_gain_top.sv
// ----------------------------------------------------------------------------
// tb_neighbor_partition_move_gain_top
// Self-checking bench for the neighbour partition move gain block. Neighbour
// runs are streamed in and every result transfer is compared against a
// behavioural predictor with its own partition histogram or a hand-worked
// result. A directed table covers the corner cases and a run with a tie
// between equal counts. Random phases then vary active_parts and, but for
// the last two, may apply random idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module tb_neighbor_partition_move_gain_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 80;      // items per random phase, at least

    // one neighbour item as it crosses the input stream
    typedef struct packed {
        logic [npmg_pkg::NODE_W-1:0] node;
        npmg_pkg::part_t             own;
        npmg_pkg::part_t             nb;
        logic                        has_nb;
        logic                        is_last;
    } nb_item_t;

    // one move gain result
    typedef struct packed {
        logic [npmg_pkg::NODE_W-1:0] node;
        npmg_pkg::part_t             from_part;
        npmg_pkg::part_t             to_part;
        logic [npmg_pkg::GAIN_W-1:0] gain;
        logic                        move;
        logic                        bad;
    } gain_result_t;

    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

    // directed table row; an item row is sent reps times, last only on the final copy
    typedef struct {
        row_kind_t                     kind;
        logic [npmg_pkg::ACTIVE_W-1:0] cfg;
        nb_item_t                      item;
        int                            reps;
        bit                            typed;
        gain_result_t                  want;
    } row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [npmg_pkg::ACTIVE_W-1:0]   cfg_wr_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // node_id, own_part, neighbor_part, zero fill
    logic [npmg_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                            s_axis_tuser;   // has_neighbor
    logic                            s_axis_tlast;   // last
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // node_out, from_part, to_part, gain, move, bad_part, zero fill
    logic [npmg_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // predictor state
    npmg_pkg::count_t              hist [npmg_pkg::MAX_PARTS];
    npmg_pkg::count_t              top_count;
    npmg_pkg::part_t               top_part;
    bit                            out_of_range_seen;
    logic [npmg_pkg::ACTIVE_W-1:0] active_parts;

    gain_result_t pending_gains [$];
    row_t         dir_rows [$];
    int           gap_pct;
    int           stall_pct;
    int           mismatches = 0;
    int           cycle_cnt  = 0;

    neighbor_partition_move_gain_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // active count as the block uses it: 0 acts as 1, above 64 as 64
    function automatic int clamp_active(input logic [npmg_pkg::ACTIVE_W-1:0] v);
        if (v < npmg_pkg::ACTIVE_MIN)
            return 1;
        if (v > npmg_pkg::ACTIVE_RESET)
            return npmg_pkg::MAX_PARTS;
        return int'(v);
    endfunction

    function automatic void clear_hist();
        foreach (hist[i])
            hist[i] = '0;
        top_count         = '0;
        top_part          = '0;
        out_of_range_seen = 1'b0;
    endfunction

    // histogram update for one neighbour; gives the result on the last item of a run
    function automatic void tally_neighbor(input nb_item_t it, output bit done,
                                           output gain_result_t res);
        int               lim;
        int               own_cnt;
        int               diff;
        npmg_pkg::count_t c;
        lim  = clamp_active(active_parts);
        done = 1'b0;
        res  = '0;
        if (it.has_nb)
        begin
            if (int'(it.nb) >= lim)
                out_of_range_seen = 1'b1;
            else if (hist[it.nb] != npmg_pkg::COUNT_MAX)
            begin
                c = hist[it.nb] + 1'b1;
                hist[it.nb] = c;
                if (c > top_count || (c == top_count && it.nb < top_part))
                begin
                    top_count = c;
                    top_part  = it.nb;
                end
            end
        end
        if (!it.is_last)
            return;
        own_cnt       = (int'(it.own) < lim) ? int'(hist[it.own]) : 0;
        diff          = int'(top_count) - own_cnt;
        res.node      = it.node;
        res.from_part = it.own;
        res.to_part   = top_part;
        res.gain      = (diff > 65535) ? 16'hFFFF : npmg_pkg::GAIN_W'(diff);
        res.move      = (diff > 0);
        res.bad       = out_of_range_seen;
        done          = 1'b1;
        clear_hist();
    endfunction

    function automatic row_t cfg_row(input logic [npmg_pkg::ACTIVE_W-1:0] v);
        row_t r;
        r = '{kind: ROW_CFG, cfg: v, item: '0, reps: 1, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic row_t item_row(input logic [npmg_pkg::NODE_W-1:0] node,
                                      input npmg_pkg::part_t own,
                                      input npmg_pkg::part_t nb, input bit has,
                                      input bit lst, input int reps = 1);
        row_t r;
        r = '{kind: ROW_ITEM, cfg: '0, item: '{node, own, nb, has, lst}, reps: reps,
              typed: 1'b0, want: '0};
        return r;
    endfunction

    // attach a hand-worked result to an item row
    function automatic row_t with_result(input row_t r0, input npmg_pkg::part_t to,
                                         input logic [npmg_pkg::GAIN_W-1:0] gain,
                                         input bit mv, input bit bad);
        row_t r;
        r       = r0;
        r.typed = 1'b1;
        r.want  = '{r0.item.node, r0.item.own, to, gain, mv, bad};
        return r;
    endfunction

    // append a row to the directed table
    function automatic void add_row(input row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // append a result to the queue of results still to arrive
    function automatic void queue_result(input gain_result_t r);
        pending_gains.insert(pending_gains.size(), r);
    endfunction

    // offer one item and hold it until the transfer; optional idle burst first
    task automatic offer_item(input nb_item_t it, input bit may_gap, output bit done,
                              output gain_result_t res);
        logic [npmg_pkg::IN_DATA_W-1:0] word;
        if (may_gap && gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        word = '0;
        word[npmg_pkg::IN_NODE_LO +: npmg_pkg::NODE_W] = it.node;
        word[npmg_pkg::IN_OWN_LO  +: npmg_pkg::PART_W] = it.own;
        word[npmg_pkg::IN_NB_LO   +: npmg_pkg::PART_W] = it.nb;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= it.has_nb;
        s_axis_tlast  <= it.is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tally_neighbor(it, done, res);
    endtask

    // register write once the block has drained
    task automatic write_active(input logic [npmg_pkg::ACTIVE_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_gains.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        active_parts = v;
    endtask

    // output side: random stall bursts
    initial
    begin
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        gain_result_t got;
        gain_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.node      = m_axis_tdata[npmg_pkg::OUT_NODE_LO +: npmg_pkg::NODE_W];
            got.from_part = m_axis_tdata[npmg_pkg::OUT_FROM_LO +: npmg_pkg::PART_W];
            got.to_part   = m_axis_tdata[npmg_pkg::OUT_TO_LO +: npmg_pkg::PART_W];
            got.gain      = m_axis_tdata[npmg_pkg::OUT_GAIN_LO +: npmg_pkg::GAIN_W];
            got.move      = m_axis_tdata[npmg_pkg::OUT_MOVE_B];
            got.bad       = m_axis_tdata[npmg_pkg::OUT_BAD_B];
            if (pending_gains.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: node %h from %0d to %0d gain %0d",
                             got.node, got.from_part, got.to_part, got.gain);
            end
            else
            begin
                want = pending_gains.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp node %h from %0d to %0d gain %0d mv %b bad %b",
                                 want.node, want.from_part, want.to_part, want.gain,
                                 want.move, want.bad);
                        $display("          got node %h from %0d to %0d gain %0d mv %b bad %b",
                                 got.node, got.from_part, got.to_part, got.gain,
                                 got.move, got.bad);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb_neighbor_partition_move_gain_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        nb_item_t                      it;
        gain_result_t                  res;
        bit                            done;
        row_t                          row;
        npmg_pkg::part_t               hot [3];
        npmg_pkg::part_t               own_pick;
        logic [npmg_pkg::NODE_W-1:0]   node_base;
        logic [npmg_pkg::ACTIVE_W-1:0] cfgv;
        int                            lim;
        int                            run_len;
        int                            phase_items;
        int                            pick;

        gap_pct       = 0;
        stall_pct     = 0;
        active_parts  = npmg_pkg::ACTIVE_RESET;
        clear_hist();
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        add_row(with_result(item_row(0, 0, 0, 0, 1), 0, 0, 0, 0));    // empty node
        add_row(with_result(item_row(31'h7FFF_FFFF, 63, 63, 1, 1), 63, 0, 0, 0));
        add_row(item_row(100, 10, 10, 1, 0));
        add_row(item_row(100, 10, 20, 1, 0));
        add_row(item_row(100, 10, 20, 1, 0));
        add_row(item_row(100, 10, 33, 0, 1));     // closes without a neighbour
        add_row(item_row(200, 0, 7, 1, 0));       // tie goes to the lower index
        add_row(item_row(200, 0, 4, 1, 1));
        add_row(item_row(300, 1, 1, 1, 0));       // ids differ inside the run
        add_row(item_row(301, 2, 2, 0, 0));
        add_row(item_row(31'h2AAA_AAAA, 42, 1, 1, 1));
        add_row(cfg_row(3));
        add_row(item_row(400, 1, 3, 1, 0));       // neighbour beyond active count
        add_row(with_result(item_row(400, 1, 1, 1, 1), 1, 0, 0, 1));
        add_row(item_row(401, 40, 2, 1, 0));      // own partition out of range
        add_row(with_result(item_row(401, 40, 2, 1, 1), 2, 2, 1, 0));
        add_row(cfg_row(0));                      // acts as one partition
        add_row(item_row(500, 0, 1, 1, 0));
        add_row(with_result(item_row(500, 0, 0, 1, 1), 0, 0, 0, 1));
        add_row(cfg_row(127));                    // acts as 64
        add_row(with_result(item_row(31'h5555_5555, 21, 63, 1, 1), 63, 1, 1, 0));
        add_row(cfg_row(1));
        add_row(with_result(item_row(600, 5, 0, 1, 1), 0, 1, 1, 0));
        add_row(cfg_row(64));
        // four neighbours each in 5 and 3; the tie goes to 3
        add_row(item_row(700, 0, 5, 1, 0, 4));
        add_row(with_result(item_row(700, 0, 3, 1, 1, 4), 3, 4, 1, 0));

        gap_pct   = 12;
        stall_pct = 12;
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
                write_active(row.cfg);
            else
            begin
                for (int k = 0; k < row.reps; k++)
                begin
                    it         = row.item;
                    it.is_last = row.item.is_last && (k == row.reps - 1);
                    offer_item(it, row.reps == 1, done, res);
                    if (done)
                        queue_result(row.typed ? row.want : res);
                end
            end
        end

        // random phases: well-formed runs with random content
        for (int ph = 0; ph < 14; ph++)
        begin
            unique case (ph)
                0:       cfgv = npmg_pkg::ACTIVE_W'(1);
                1:       cfgv = npmg_pkg::ACTIVE_W'(64);
                2:       cfgv = npmg_pkg::ACTIVE_W'(0);
                3:       cfgv = npmg_pkg::ACTIVE_W'(127);
                default: cfgv = ($urandom_range(0, 7) == 0)
                              ? npmg_pkg::ACTIVE_W'($urandom_range(0, 127))
                              : npmg_pkg::ACTIVE_W'($urandom_range(1, 64));
            endcase
            write_active(cfgv);
            lim = clamp_active(cfgv);
            foreach (hot[j])
                hot[j] = npmg_pkg::PART_W'($urandom_range(0, lim - 1));
            if (ph >= 12)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 40);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 40);
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                run_len   = $urandom_range(1, 12);
                node_base = npmg_pkg::NODE_W'($urandom);
                own_pick  = $urandom_range(0, 1) ? hot[$urandom_range(0, 2)]
                                                 : npmg_pkg::PART_W'($urandom_range(0, 63));
                for (int k = 0; k < run_len; k++)
                begin
                    it.node    = ($urandom_range(0, 9) == 0) ? npmg_pkg::NODE_W'($urandom)
                                                             : node_base;
                    it.own     = ($urandom_range(0, 9) == 0)
                               ? npmg_pkg::PART_W'($urandom_range(0, 63)) : own_pick;
                    pick       = $urandom_range(0, 99);
                    it.has_nb  = (pick < 88);
                    it.nb      = (pick < 70) ? hot[$urandom_range(0, 2)]
                                             : npmg_pkg::PART_W'($urandom_range(0, 63));
                    it.is_last = (k == run_len - 1);
                    offer_item(it, 1'b1, done, res);
                    if (done)
                        queue_result(res);
                end
                phase_items += run_len;
            end
        end

        // drain
        s_axis_tvalid <= 1'b0;
        while (pending_gains.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_neighbor_partition_move_gain_top: done, clean");
        else
            $display("tb_neighbor_partition_move_gain_top: done, errors");
        $finish;
    end

endmodule
